/* rtl/core/dpod_pkg.sv */
// shared types, constants and calendar functions for the date period overlap block
package dpod_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int DateW  = DayW + MonthW + YearW;
  localparam int NumDates = 4;
  localparam int InDataW  = ((NumDates * DateW + 7) / 8) * 8;
  localparam int UserW    = 2;

  localparam logic [YearW-1:0]  YearMax  = YearW'(9999);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);

  // floor(y / 100) == (y * Recip100) >> Recip100Shift for every 14-bit y
  localparam int Recip100W     = 13;
  localparam int Recip100Shift = 19;
  localparam int ProdW         = YearW + Recip100W;
  localparam int QuotW         = ProdW - Recip100Shift;
  localparam logic [Recip100W-1:0] Recip100 = Recip100W'(5243);
  localparam logic [YearW-1:0]     Century  = YearW'(100);

  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DayW-1:0] FebLeapLen = DayW'(29);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    logic  valid;
    date_t next;
  } day_info_t;

  function automatic logic [DayW-1:0] days_in_month(logic [MonthW-1:0] month, logic leap);
    logic [DayW-1:0] len;
    len = '0;
    if (month == MonthFeb) begin
      len = leap ? FebLeapLen : MonthLen[1];
    end else if (month >= MonthW'(1) && month <= MonthDec) begin
      len = MonthLen[month - MonthW'(1)];
    end
    return len;
  endfunction

endpackage

/* rtl/core/dpod_day_unit.sv */
// shared calendar unit: date validity and next-day increment with leap-year rule
module dpod_day_unit (
  input  dpod_pkg::date_t     date_i,
  output dpod_pkg::day_info_t info_o
);

  logic [dpod_pkg::ProdW-1:0]  prod;
  logic [dpod_pkg::QuotW-1:0]  quot100;
  logic [dpod_pkg::YearW-1:0]  rem100;
  logic                        leap;
  logic [dpod_pkg::DayW-1:0]   dim;
  dpod_pkg::date_t             next;

  always_comb begin
    prod    = dpod_pkg::ProdW'(date_i.year) * dpod_pkg::ProdW'(dpod_pkg::Recip100);
    quot100 = prod[dpod_pkg::ProdW-1:dpod_pkg::Recip100Shift];
    rem100  = date_i.year - dpod_pkg::YearW'(dpod_pkg::YearW'(quot100) * dpod_pkg::Century);
    // divisible by 4, and either not a century or a century divisible by 400
    leap    = (date_i.year[1:0] == 2'b00) && ((rem100 != '0) || (quot100[1:0] == 2'b00));
    dim     = dpod_pkg::days_in_month(date_i.month, leap);
  end

  always_comb begin
    next = date_i;
    if (date_i.day == dim) begin
      next.day = dpod_pkg::DayW'(1);
      if (date_i.month == dpod_pkg::MonthDec) begin
        next.month = dpod_pkg::MonthW'(1);
        next.year  = date_i.year + dpod_pkg::YearW'(1);
      end else begin
        next.month = date_i.month + dpod_pkg::MonthW'(1);
      end
    end else begin
      next.day = date_i.day + dpod_pkg::DayW'(1);
    end
  end

  assign info_o.valid = (date_i.year >= dpod_pkg::YearW'(1)) &&
                        (date_i.year <= dpod_pkg::YearMax) &&
                        (date_i.month >= dpod_pkg::MonthW'(1)) &&
                        (date_i.month <= dpod_pkg::MonthDec) &&
                        (date_i.day >= dpod_pkg::DayW'(1)) &&
                        (date_i.day <= dim);
  assign info_o.next  = next;

endmodule

/* rtl/core/date_period_overlap_days.sv */
// top level: inclusive day overlap of two gregorian date periods
//
// one input transaction on the s_axis channel carries four dates: first
// period start and end, second period start and end. one result
// transaction on the m_axis channel returns the number of days common to
// both periods, ends included, with flags for saturation and bad input.
// the block takes one transaction at a time: s_axis_tready_o is high
// only while idle. after acceptance the shared calendar unit checks the
// four dates one at a time, then walks the overlap one day per cycle,
// counting at most 2^COUNT_BITS - 1 days before it saturates; invalid
// or empty input skips the walk. a finished result sits in an output
// register; the next transaction is accepted while it waits, and a
// second result holds in a done state until the receiver takes the
// first. reset returns the sequencer to idle and drops any pending
// result.
module date_period_overlap_days #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // first_start_day, first_start_month, first_start_year, first_end_day,
  // first_end_month, first_end_year, second_start_day, second_start_month,
  // second_start_year, second_end_day, second_end_month, second_end_year
  input  logic [dpod_pkg::InDataW-1:0] s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // overlap_days
  output logic [((COUNT_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // count_saturated, input_error
  output logic [dpod_pkg::UserW-1:0]   m_axis_tuser_o
);

  localparam int OutDataW = ((COUNT_BITS + 7) / 8) * 8;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              idx_q, idx_d;
  logic                    err_q, err_d;
  logic                    out_valid_q, out_valid_d;

  dpod_pkg::date_t         s1_q, s1_d, e1_q, e1_d, s2_q, s2_d, e2_q, e2_d;
  dpod_pkg::date_t         walk_q, walk_d, hi_q, hi_d;
  logic [COUNT_BITS-1:0]   tally_q, tally_d;
  logic [COUNT_BITS-1:0]   res_days_q, res_days_d;
  logic                    res_sat_q, res_sat_d, res_err_q, res_err_d;
  logic [COUNT_BITS-1:0]   out_days_q, out_days_d;
  logic                    out_sat_q, out_sat_d, out_err_q, out_err_d;

  dpod_pkg::date_t         check_date, unit_date, lo, hi;
  dpod_pkg::day_info_t     info;
  logic                    err_now;

  always_comb begin
    unique case (idx_q)
      2'd0:    check_date = s1_q;
      2'd1:    check_date = e1_q;
      2'd2:    check_date = s2_q;
      default: check_date = e2_q;
    endcase
  end

  assign unit_date = (state_q == S_WALK) ? walk_q : check_date;

  dpod_day_unit u_day_unit (
    .date_i (unit_date),
    .info_o (info)
  );

  assign lo      = (s1_q > s2_q) ? s1_q : s2_q;
  assign hi      = (e1_q < e2_q) ? e1_q : e2_q;
  assign err_now = err_q | ~info.valid;

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    s1_d        = s1_q;
    e1_d        = e1_q;
    s2_d        = s2_q;
    e2_d        = e2_q;
    walk_d      = walk_q;
    hi_d        = hi_q;
    tally_d     = tally_q;
    res_days_d  = res_days_q;
    res_sat_d   = res_sat_q;
    res_err_d   = res_err_q;
    out_days_d  = out_days_q;
    out_sat_d   = out_sat_q;
    out_err_d   = out_err_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          s1_d    = dpod_pkg::date_t'(s_axis_tdata_i[0*dpod_pkg::DateW +: dpod_pkg::DateW]);
          e1_d    = dpod_pkg::date_t'(s_axis_tdata_i[1*dpod_pkg::DateW +: dpod_pkg::DateW]);
          s2_d    = dpod_pkg::date_t'(s_axis_tdata_i[2*dpod_pkg::DateW +: dpod_pkg::DateW]);
          e2_d    = dpod_pkg::date_t'(s_axis_tdata_i[3*dpod_pkg::DateW +: dpod_pkg::DateW]);
          idx_d   = 2'd0;
          err_d   = 1'b0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_d = idx_q + 2'd1;
        err_d = err_now;
        if (idx_q == 2'd3) begin
          priority if (err_now || (s1_q > e1_q)) begin
            res_days_d = '0;
            res_sat_d  = 1'b0;
            res_err_d  = 1'b1;
            state_d    = S_DONE;
          end else if (lo > hi) begin
            res_days_d = '0;
            res_sat_d  = 1'b0;
            res_err_d  = 1'b0;
            state_d    = S_DONE;
          end else begin
            walk_d  = lo;
            hi_d    = hi;
            tally_d = COUNT_BITS'(1);
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        priority if (walk_q == hi_q) begin
          res_days_d = tally_q;
          res_sat_d  = 1'b0;
          res_err_d  = 1'b0;
          state_d    = S_DONE;
        end else if (tally_q == CountMax) begin
          res_days_d = CountMax;
          res_sat_d  = 1'b1;
          res_err_d  = 1'b0;
          state_d    = S_DONE;
        end else begin
          walk_d  = info.next;
          tally_d = tally_q + COUNT_BITS'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_days_d  = res_days_q;
          out_sat_d   = res_sat_q;
          out_err_d   = res_err_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
      tally_q     <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      walk_q      <= walk_d;
      tally_q     <= tally_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= s1_d;
    e1_q       <= e1_d;
    s2_q       <= s2_d;
    e2_q       <= e2_d;
    hi_q       <= hi_d;
    res_days_q <= res_days_d;
    res_sat_q  <= res_sat_d;
    res_err_q  <= res_err_d;
    out_days_q <= out_days_d;
    out_sat_q  <= out_sat_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_days_q);
  assign m_axis_tuser_o  = {out_err_q, out_sat_q};

  // an error result never carries a count or a saturation flag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (out_days_q == '0) && !m_axis_tuser_o[0])
    else $error("error result with nonzero count");

  // saturation only ever reports the full-scale count
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (out_days_q == CountMax))
    else $error("saturated result below full scale");

  // the walk never passes the overlap end and the tally never wraps to zero
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (walk_q <= hi_q) && (tally_q != '0))
    else $error("day walk out of range");

  // an accepted transaction always starts the date check at the first date
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == S_CHECK) && (idx_q == 2'd0))
    else $error("accepted transaction did not start the check");

endmodule

/* tb/sv/overlap_days_checker.sv */
// checker for the date period overlap block: predicts each result and compares it
`timescale 1ns / 100ps
module overlap_days_checker
  import dpod_pkg::*;
#(
  parameter int CountBits = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  input  logic                                 s_axis_tready_i,
  input  logic [InDataW-1:0]                   s_axis_tdata_i,
  input  logic                                 m_axis_tvalid_i,
  input  logic                                 m_axis_tready_i,
  input  logic [((CountBits+7)/8)*8-1:0]       m_axis_tdata_i,
  input  logic [UserW-1:0]                     m_axis_tuser_i,
  output int                                   outstanding_o,
  output int                                   errors_o
);

  localparam int OutW = ((CountBits + 7) / 8) * 8;
  localparam longint unsigned CountMax = (longint'(1) << CountBits) - 1;

  typedef struct packed {
    logic [OutW-1:0] days;
    logic            saturated;
    logic            bad_input;
  } overlap_t;

  overlap_t pending_overlaps [$];
  overlap_t want;
  int       fails = 0;

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      2: return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic bit date_valid(date_t d);
    if (d.year < 1 || d.year > YearMax) return 1'b0;
    if (d.month < 1 || d.month > MonthDec) return 1'b0;
    return (d.day >= 1) && (d.day <= month_length(d.year, d.month));
  endfunction

  // days since the start of the calendar, 1 for the first day of year 1
  function automatic int unsigned day_index(date_t d);
    int unsigned past;
    int unsigned total;
    int unsigned m;
    past = d.year - 1;
    total = 365 * past + past / 4 - past / 100 + past / 400;
    for (m = 1; m < d.month; m++) total += month_length(d.year, m);
    return total + d.day;
  endfunction

  function automatic overlap_t predict_overlap(logic [InDataW-1:0] word);
    date_t           dates [NumDates];
    int unsigned     idx [NumDates];
    int unsigned     lo;
    int unsigned     hi;
    longint unsigned span;
    bit              good;
    overlap_t        r;
    int              k;
    good = 1'b1;
    r = '0;
    for (k = 0; k < NumDates; k++) begin
      dates[k] = word[k*DateW +: DateW];
      if (!date_valid(dates[k])) good = 1'b0;
    end
    if (good) begin
      for (k = 0; k < NumDates; k++) idx[k] = day_index(dates[k]);
      if (idx[0] > idx[1]) good = 1'b0;
    end
    if (!good) begin
      r.bad_input = 1'b1;
      return r;
    end
    // dates: first start, first end, second start, second end
    lo = (idx[0] > idx[2]) ? idx[0] : idx[2];
    hi = (idx[1] < idx[3]) ? idx[1] : idx[3];
    span = (lo <= hi) ? longint'(hi - lo) + 1 : 0;
    if (span > CountMax) begin
      r.days = OutW'(CountMax);
      r.saturated = 1'b1;
    end else begin
      r.days = OutW'(span);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_overlaps.delete();
      outstanding_o <= 0;
      errors_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_overlaps.size() == 0) begin
          $display("%0t: unexpected result transaction, actual days %0d flags %b",
                   $time, m_axis_tdata_i, m_axis_tuser_i);
          fails++;
        end else begin
          want = pending_overlaps.pop_front();
          if (m_axis_tdata_i !== want.days) begin
            $display("%0t: overlap_days expected %0d actual %0d",
                     $time, want.days, m_axis_tdata_i);
            fails++;
          end
          if (m_axis_tuser_i[0] !== want.saturated) begin
            $display("%0t: count_saturated expected %b actual %b",
                     $time, want.saturated, m_axis_tuser_i[0]);
            fails++;
          end
          if (m_axis_tuser_i[1] !== want.bad_input) begin
            $display("%0t: input_error expected %b actual %b",
                     $time, want.bad_input, m_axis_tuser_i[1]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_overlaps.push_back(predict_overlap(s_axis_tdata_i));
      end
      outstanding_o <= pending_overlaps.size();
      errors_o <= fails;
    end
  end

endmodule

/* tb/sv/tb_date_period_overlap_days.sv */
// testbench top for the date period overlap block: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_date_period_overlap_days;
  import dpod_pkg::*;

  localparam int CountBits   = 16;
  localparam int OutW        = ((CountBits + 7) / 8) * 8;
  localparam int RandomItems = 1025;
  localparam int CalmItems   = 150;

  typedef enum int {
    WellFormed,
    ReversedFirst,
    BadDate,
    RawNoise
  } item_kind_e;

  typedef enum int {
    DayZero,
    DayPastEnd,
    MonthOut,
    YearOut
  } spoil_kind_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OutW-1:0]    m_tdata;
  logic [UserW-1:0]   m_tuser;
  logic               calm_tail = 1'b0;
  int                 outstanding;
  int                 fails;

  always #2 clk = ~clk;

  date_period_overlap_days #(
    .COUNT_BITS(CountBits)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  overlap_days_checker #(
    .CountBits(CountBits)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .outstanding_o   (outstanding),
    .errors_o        (fails)
  );

  function automatic date_t mk_date(int unsigned d, int unsigned m, int unsigned y);
    date_t r;
    r.day = DayW'(d);
    r.month = MonthW'(m);
    r.year = YearW'(y);
    return r;
  endfunction

  function automatic logic is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic date_t next_day(date_t x);
    date_t r;
    r = x;
    if (x.day < days_in_month(x.month, is_leap(x.year))) begin
      r.day = x.day + 1'b1;
    end else begin
      r.day = DayW'(1);
      if (x.month == MonthDec) begin
        r.month = MonthW'(1);
        r.year = x.year + 1'b1;
      end else begin
        r.month = x.month + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic date_t advance(date_t x, int unsigned n);
    date_t r;
    r = x;
    repeat (n) r = next_day(r);
    return r;
  endfunction

  // years near century boundaries come up often so that the leap rule gets walked
  function automatic date_t any_date();
    int unsigned y;
    int unsigned m;
    if ($urandom_range(0, 3) == 0) begin
      y = 100 * $urandom_range(1, 99) - $urandom_range(0, 1);
    end else begin
      y = $urandom_range(1, 9997);
    end
    m = $urandom_range(1, 12);
    return mk_date($urandom_range(1, days_in_month(MonthW'(m), is_leap(y))), m, y);
  endfunction

  function automatic date_t spoil(date_t x);
    date_t           r;
    logic [DayW-1:0] len;
    r = x;
    len = days_in_month(x.month, is_leap(x.year));
    case (spoil_kind_e'($urandom_range(DayZero, YearOut)))
      DayZero: r.day = '0;
      DayPastEnd: r.day = (len == DayW'(31)) ? '0 : DayW'($urandom_range(len + 1, 31));
      MonthOut: r.month = $urandom_range(0, 1) ? '0 : MonthW'($urandom_range(13, 15));
      default: r.year = $urandom_range(0, 1) ? '0 : YearW'($urandom_range(10000, 16383));
    endcase
    return r;
  endfunction

  task automatic send_item(logic [InDataW-1:0] word);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_periods(date_t s1, date_t e1, date_t s2, date_t e2);
    send_item({e2, s2, e1, s1});
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random();
    date_t              quad [NumDates];
    date_t              base;
    date_t              swap;
    item_kind_e         kind;
    int unsigned        pick;
    logic [InDataW-1:0] word;
    pick = $urandom_range(0, 19);
    kind = (pick < 14) ? WellFormed : (pick < 16) ? ReversedFirst :
           (pick < 18) ? BadDate : RawNoise;
    base = any_date();
    quad[0] = advance(base, $urandom_range(0, 300));
    quad[1] = advance(quad[0], $urandom_range(0, 400));
    quad[2] = ($urandom_range(0, 19) == 0) ? any_date() :
              advance(base, $urandom_range(0, 700));
    quad[3] = advance(quad[2], $urandom_range(0, 400));
    if ($urandom_range(0, 9) == 0) begin
      swap = quad[2];
      quad[2] = quad[3];
      quad[3] = swap;
    end
    case (kind)
      ReversedFirst: quad[0] = advance(quad[1], $urandom_range(1, 400));
      BadDate: begin
        pick = $urandom_range(0, NumDates - 1);
        quad[pick] = spoil(quad[pick]);
      end
      default: ;
    endcase
    word = {quad[3], quad[2], quad[1], quad[0]};
    if (kind == RawNoise) begin
      word = {$urandom, $urandom, $urandom};
      word[InDataW-1:NumDates*DateW] = '0;
    end
    send_item(word);
  endtask

  // result side: stall bursts, with clear stretches now and then
  initial begin
    int unsigned stall_left;
    int unsigned clear_left;
    stall_left = 0;
    clear_left = 0;
    forever begin
      @(posedge clk);
      if (calm_tail || clear_left != 0) begin
        m_tready <= 1'b1;
        if (clear_left != 0) clear_left--;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0) clear_left = $urandom_range(200, 2000);
      end
    end
  end

  initial begin
    date_t lead;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_periods(mk_date(1, 1, 1), mk_date(1, 1, 1), mk_date(1, 1, 1), mk_date(1, 1, 1));
    send_periods(mk_date(31, 12, 9999), mk_date(31, 12, 9999),
                 mk_date(31, 12, 9999), mk_date(31, 12, 9999));
    // leap day in a year divisible by 400, non-leap centuries, and 29 February in years without one
    send_periods(mk_date(28, 2, 2000), mk_date(1, 3, 2000),
                 mk_date(29, 2, 2000), mk_date(31, 12, 2000));
    send_periods(mk_date(28, 2, 2100), mk_date(1, 3, 2100),
                 mk_date(1, 1, 2100), mk_date(31, 12, 2100));
    send_periods(mk_date(29, 2, 1900), mk_date(1, 3, 1900),
                 mk_date(1, 1, 1900), mk_date(31, 12, 1900));
    send_periods(mk_date(1, 1, 2004), mk_date(29, 2, 2004),
                 mk_date(1, 2, 2003), mk_date(29, 2, 2003));
    // invalid fields
    send_periods(mk_date(0, 1, 2020), mk_date(1, 2, 2020),
                 mk_date(1, 1, 2020), mk_date(1, 2, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(31, 4, 2020),
                 mk_date(1, 1, 2020), mk_date(1, 2, 2020));
    send_periods(mk_date(1, 0, 2020), mk_date(1, 2, 2020),
                 mk_date(1, 1, 2020), mk_date(1, 2, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(1, 13, 2020),
                 mk_date(1, 1, 2020), mk_date(1, 2, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(1, 2, 2020),
                 mk_date(31, 15, 16383), mk_date(1, 2, 2020));
    send_periods(mk_date(1, 1, 0), mk_date(1, 2, 2020),
                 mk_date(1, 1, 2020), mk_date(1, 2, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(1, 2, 2020),
                 mk_date(1, 1, 2020), mk_date(31, 12, 10000));
    // reversed periods, disjoint, touching, containment, year crossing
    send_periods(mk_date(2, 1, 2020), mk_date(1, 1, 2020),
                 mk_date(1, 1, 2020), mk_date(31, 12, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(31, 12, 2020),
                 mk_date(1, 6, 2020), mk_date(31, 5, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(31, 1, 2020),
                 mk_date(1, 2, 2020), mk_date(28, 2, 2020));
    send_periods(mk_date(1, 1, 2020), mk_date(31, 1, 2020),
                 mk_date(31, 1, 2020), mk_date(10, 2, 2020));
    send_periods(mk_date(10, 3, 2020), mk_date(5, 4, 2020),
                 mk_date(1, 1, 2019), mk_date(31, 12, 2021));
    send_periods(mk_date(1, 12, 2023), mk_date(31, 1, 2024),
                 mk_date(15, 12, 2023), mk_date(15, 1, 2024));
    send_periods(mk_date(1, 1, 1), mk_date(31, 12, 1),
                 mk_date(1, 1, 9999), mk_date(31, 12, 9999));
    // count at the top of its range and just past it
    lead = advance(mk_date(1, 1, 1900), 65534);
    send_periods(mk_date(1, 1, 1900), lead, mk_date(1, 1, 1), mk_date(31, 12, 9999));
    send_periods(mk_date(1, 1, 1900), next_day(lead),
                 mk_date(1, 1, 1), mk_date(31, 12, 9999));
    send_periods(mk_date(1, 1, 1), mk_date(31, 12, 9999),
                 mk_date(1, 1, 1), mk_date(31, 12, 9999));
    wait_for_results();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) wait_for_results();
      if (n == RandomItems - CalmItems) calm_tail = 1'b1;
      send_random();
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
